/* design/ute_pkg.sv */
// ----------------------------------------------------------------------------
// ute_pkg: shared types, constants and tables of the timestamp converter
// Holds the record passed from the parser to the converter, the converter's
// state type and the calendar and scale tables.
// ----------------------------------------------------------------------------
package ute_pkg;

  // ASCII codes of the separators
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Character positions with a meaning of their own
  localparam logic [4:0] POS_SHORT    = 5'd19;  // 'Z' here: no fraction
  localparam logic [4:0] POS_FRAC_LO  = 5'd21;  // first legal 'Z' after a fraction
  localparam logic [4:0] POS_FRAC_HI  = 5'd29;  // last legal 'Z' position
  localparam logic [4:0] POS_SAT      = 5'd31;

  // Time constants
  localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;
  localparam logic [11:0] SEC_PER_HR  = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;
  localparam logic [6:0]  MAX_HOUR    = 7'd23;
  localparam logic [6:0]  MAX_MINUTE  = 7'd59;
  localparam logic [6:0]  MAX_SECOND  = 7'd59;
  localparam logic [23:0] EPOCH_DAYS  = 24'd719468;  // March-based day count of 1970-01-01
  localparam logic [12:0] RECIP_100   = 13'd5243;    // ceil(2^19 / 100)
  localparam int unsigned RECIP_SHIFT = 19;

  // One parsed string, handed from the parser to the converter
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [29:0] frac;
    logic [4:0]  last_pos;
    logic        fmt_ok;
  } ute_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DAYA,
    ST_DAYB,
    ST_SECS,
    ST_MLO,
    ST_MHI,
    ST_SUM
  } ute_state_e;

  function automatic logic ute_is_digit(logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Days in a month; zero for a month code outside 1..12
  function automatic logic [4:0] ute_month_days(logic [6:0] month, logic leap);
    logic [4:0] d;
    case (month) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    d = 5'd30;
      7'd2:                                        d = leap ? 5'd29 : 5'd28;
      default:                                     d = 5'd0;
    endcase
    return d;
  endfunction

  // Day of a year that starts on March 1, for the first day of each month
  function automatic logic [8:0] ute_month_doy(logic [6:0] month);
    logic [8:0] d;
    case (month)
      7'd1:    d = 9'd306;
      7'd2:    d = 9'd337;
      7'd3:    d = 9'd0;
      7'd4:    d = 9'd31;
      7'd5:    d = 9'd61;
      7'd6:    d = 9'd92;
      7'd7:    d = 9'd122;
      7'd8:    d = 9'd153;
      7'd9:    d = 9'd184;
      7'd10:   d = 9'd214;
      7'd11:   d = 9'd245;
      7'd12:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Scale of the fraction to nanoseconds, by position of the closing 'Z'
  function automatic logic [29:0] ute_frac_scale(logic [4:0] last_pos);
    logic [29:0] s;
    case (last_pos)
      5'd21:   s = 30'd100000000;
      5'd22:   s = 30'd10000000;
      5'd23:   s = 30'd1000000;
      5'd24:   s = 30'd100000;
      5'd25:   s = 30'd10000;
      5'd26:   s = 30'd1000;
      5'd27:   s = 30'd100;
      5'd28:   s = 30'd10;
      5'd29:   s = 30'd1;
      default: s = 30'd0;
    endcase
    return s;
  endfunction

endpackage

/* design/ute_front.sv */
// ----------------------------------------------------------------------------
// ute_front: character parser
// Checks each character against its position, accumulates the decimal
// fields and hands one record per string to the queue on the last beat.
// ----------------------------------------------------------------------------
module ute_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        char_in_i,
  input  logic              is_last_i,
  output logic              enq_o,
  output ute_pkg::ute_rec_t rec_o
);

  logic [4:0]  pos_q,    pos_d;
  logic [13:0] year_q,   year_d;
  logic [6:0]  month_q,  month_d;
  logic [6:0]  day_q,    day_d;
  logic [6:0]  hour_q,   hour_d;
  logic [6:0]  minute_q, minute_d;
  logic [6:0]  second_q, second_d;
  logic [29:0] frac_q,   frac_d;
  logic        ferr_q,   ferr_d;
  logic        dig;
  logic [3:0]  dval;

  assign dig  = ute_pkg::ute_is_digit(char_in_i);
  assign dval = char_in_i[3:0];

  always_comb begin
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    frac_d   = frac_q;
    ferr_d   = ferr_q;
    pos_d    = pos_q;
    enq_o    = 1'b0;
    rec_o    = '0;
    if (accept_i) begin
      case (pos_q) inside
        [5'd30:5'd31]: ferr_d = 1'b1;
        [5'd0:5'd3]: begin
          if (dig) year_d = 14'(year_q * 14'd10) + 14'(dval);
          else     ferr_d = 1'b1;
        end
        5'd4, 5'd7: begin
          if (char_in_i != ute_pkg::CHAR_DASH) ferr_d = 1'b1;
        end
        [5'd5:5'd6]: begin
          if (dig) month_d = 7'(month_q * 7'd10) + 7'(dval);
          else     ferr_d = 1'b1;
        end
        [5'd8:5'd9]: begin
          if (dig) day_d = 7'(day_q * 7'd10) + 7'(dval);
          else     ferr_d = 1'b1;
        end
        5'd10: begin
          if (char_in_i != ute_pkg::CHAR_T) ferr_d = 1'b1;
        end
        [5'd11:5'd12]: begin
          if (dig) hour_d = 7'(hour_q * 7'd10) + 7'(dval);
          else     ferr_d = 1'b1;
        end
        5'd13, 5'd16: begin
          if (char_in_i != ute_pkg::CHAR_COLON) ferr_d = 1'b1;
        end
        [5'd14:5'd15]: begin
          if (dig) minute_d = 7'(minute_q * 7'd10) + 7'(dval);
          else     ferr_d = 1'b1;
        end
        [5'd17:5'd18]: begin
          if (dig) second_d = 7'(second_q * 7'd10) + 7'(dval);
          else     ferr_d = 1'b1;
        end
        default: begin
          if (is_last_i) begin
            if (char_in_i != ute_pkg::CHAR_Z) ferr_d = 1'b1;
          end else if (pos_q == ute_pkg::POS_SHORT) begin
            if (char_in_i != ute_pkg::CHAR_DOT) ferr_d = 1'b1;
          end else if (pos_q < ute_pkg::POS_FRAC_HI) begin
            if (dig) frac_d = 30'(frac_q * 30'd10) + 30'(dval);
            else     ferr_d = 1'b1;
          end else begin
            // a non-final character at the last legal slot: string too long
            ferr_d = 1'b1;
          end
        end
      endcase

      if (pos_q != ute_pkg::POS_SAT) pos_d = pos_q + 5'd1;

      if (is_last_i) begin
        enq_o           = 1'b1;
        rec_o.year      = year_d;
        rec_o.month     = month_d;
        rec_o.day       = day_d;
        rec_o.hour      = hour_d;
        rec_o.minute    = minute_d;
        rec_o.second    = second_d;
        rec_o.frac      = frac_d;
        rec_o.last_pos  = pos_q;
        rec_o.fmt_ok    = !ferr_d &&
                          ((pos_q == ute_pkg::POS_SHORT) ||
                           ((pos_q >= ute_pkg::POS_FRAC_LO) &&
                            (pos_q <= ute_pkg::POS_FRAC_HI)));
        // start the next string from scratch
        year_d   = '0;
        month_d  = '0;
        day_d    = '0;
        hour_d   = '0;
        minute_d = '0;
        second_d = '0;
        frac_d   = '0;
        ferr_d   = 1'b0;
        pos_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      frac_q   <= '0;
      ferr_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      frac_q   <= frac_d;
      ferr_q   <= ferr_d;
    end
  end

endmodule

/* design/ute_queue.sv */
// ----------------------------------------------------------------------------
// ute_queue: two-entry record queue
// Decouples the parser from the converter so that each can stall alone.
// ----------------------------------------------------------------------------
module ute_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              enq_i,
  input  ute_pkg::ute_rec_t rec_i,
  input  logic              deq_i,
  output ute_pkg::ute_rec_t rec_o,
  output logic              full_o,
  output logic              empty_o
);

  ute_pkg::ute_rec_t mem_q [2];
  logic              wr_ptr_q;
  logic              rd_ptr_q;
  logic [1:0]        cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (enq_i) mem_q[wr_ptr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (enq_i) wr_ptr_q <= ~wr_ptr_q;
      if (deq_i) rd_ptr_q <= ~rd_ptr_q;
      case ({enq_i, deq_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* design/ute_back.sv */
// ----------------------------------------------------------------------------
// ute_back: calendar and nanosecond converter
// Runs one record at a time through a short sequence: year divide, date checks,
// day count, seconds, then the nanosecond product in two halves and a range
// check. Holds the finished result in an output register until popped.
// ----------------------------------------------------------------------------
module ute_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ute_pkg::ute_rec_t rec_i,
  input  logic              q_empty_i,
  output logic              deq_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic              valid_res_o,
  output logic signed [63:0] epoch_ns_o
);

  ute_pkg::ute_state_e st_q, st_d;
  ute_pkg::ute_rec_t   rec_q;
  logic                res_wr;

  logic [13:0]        yy_q;
  logic [7:0]         q_y_q, q_yy_q;
  logic [18:0]        tod_q;
  logic [29:0]        frac_s_q;
  logic               date_ok_q;
  logic [23:0]        part_q;
  logic signed [23:0] days_q;
  logic signed [41:0] secs_q;
  logic [49:0]        pl_q;
  logic signed [51:0] ph_q;
  logic [50:0]        lofr_q;
  logic               res_vld_q;
  logic               res_ok_q;
  logic signed [63:0] res_ns_q;

  // datapath terms
  logic [13:0]        yy_d;
  logic [26:0]        prod_y, prod_yy;
  logic [59:0]        frac_prod;
  logic [13:0]        r100;
  logic               leap;
  logic [4:0]         mdays;
  logic               date_ok_d;
  logic signed [73:0] ns_w;
  logic               in_range;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ute_pkg::ST_IDLE: if (!q_empty_i) st_d = ute_pkg::ST_DIV;
      ute_pkg::ST_DIV:  st_d = ute_pkg::ST_DAYA;
      ute_pkg::ST_DAYA: st_d = ute_pkg::ST_DAYB;
      ute_pkg::ST_DAYB: st_d = ute_pkg::ST_SECS;
      ute_pkg::ST_SECS: st_d = ute_pkg::ST_MLO;
      ute_pkg::ST_MLO:  st_d = ute_pkg::ST_MHI;
      ute_pkg::ST_MHI:  st_d = ute_pkg::ST_SUM;
      ute_pkg::ST_SUM:  if (res_wr) st_d = ute_pkg::ST_IDLE;
      default:          st_d = ute_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    deq_o  = 1'b0;
    res_wr = 1'b0;
    unique case (st_q)
      ute_pkg::ST_IDLE: deq_o  = !q_empty_i;
      ute_pkg::ST_SUM:  res_wr = !res_vld_q || pop_i;
      default: begin
        deq_o  = 1'b0;
        res_wr = 1'b0;
      end
    endcase
  end

  // year / 100 by reciprocal; March-based year drops by one in Jan and Feb
  assign yy_d      = rec_q.year - ((rec_q.month <= 7'd2) ? 14'd1 : 14'd0);
  assign prod_y    = 27'(rec_q.year) * 27'(ute_pkg::RECIP_100);
  assign prod_yy   = 27'(yy_d) * 27'(ute_pkg::RECIP_100);
  assign frac_prod = 60'(rec_q.frac) * 60'(ute_pkg::ute_frac_scale(rec_q.last_pos));

  assign r100  = rec_q.year - (14'(q_y_q) * 14'd100);
  assign leap  = (rec_q.year[1:0] == 2'd0) && ((r100 != 14'd0) || (q_y_q[1:0] == 2'd0));
  assign mdays = ute_pkg::ute_month_days(rec_q.month, leap);
  assign date_ok_d = rec_q.fmt_ok && (rec_q.year != 14'd0) && (rec_q.day != 7'd0) &&
                     (rec_q.day <= 7'(mdays)) &&
                     (rec_q.hour <= ute_pkg::MAX_HOUR) &&
                     (rec_q.minute <= ute_pkg::MAX_MINUTE) &&
                     (rec_q.second <= ute_pkg::MAX_SECOND);

  assign ns_w     = $signed({{2{ph_q[51]}}, ph_q, 20'd0}) + $signed({23'd0, lofr_q});
  assign in_range = (ns_w[73:63] == 11'h000) || (ns_w[73:63] == 11'h7FF);

  always_ff @(posedge clk_i) begin
    if (deq_o) rec_q <= rec_i;
    if (st_q == ute_pkg::ST_DIV) begin
      yy_q     <= yy_d;
      q_y_q    <= prod_y[26:ute_pkg::RECIP_SHIFT];
      q_yy_q   <= prod_yy[26:ute_pkg::RECIP_SHIFT];
      tod_q    <= (19'(rec_q.hour) * 19'(ute_pkg::SEC_PER_HR)) +
                  (19'(rec_q.minute) * 19'(ute_pkg::SEC_PER_MIN)) + 19'(rec_q.second);
      frac_s_q <= frac_prod[29:0];
    end
    if (st_q == ute_pkg::ST_DAYA) begin
      date_ok_q <= date_ok_d;
      part_q    <= 24'(yy_q) * 24'd365 + 24'(yy_q[13:2]) - 24'(q_yy_q) + 24'(q_yy_q[7:2]);
    end
    if (st_q == ute_pkg::ST_DAYB) begin
      days_q <= $signed(part_q + 24'(ute_pkg::ute_month_doy(rec_q.month)) +
                        24'(rec_q.day) - 24'd1 - ute_pkg::EPOCH_DAYS);
    end
    if (st_q == ute_pkg::ST_SECS) begin
      secs_q <= days_q * $signed({1'b0, ute_pkg::SEC_PER_DAY}) + $signed({23'd0, tod_q});
    end
    if (st_q == ute_pkg::ST_MLO) begin
      pl_q <= 50'(secs_q[19:0]) * 50'(ute_pkg::NS_PER_SEC);
    end
    if (st_q == ute_pkg::ST_MHI) begin
      ph_q   <= $signed(secs_q[41:20]) * $signed({1'b0, ute_pkg::NS_PER_SEC});
      lofr_q <= 51'(pl_q) + 51'(frac_s_q);
    end
    if (res_wr) begin
      res_ok_q <= date_ok_q && in_range;
      res_ns_q <= (date_ok_q && in_range) ? ns_w[63:0] : 64'sd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ute_pkg::ST_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (res_wr)     res_vld_q <= 1'b1;
      else if (pop_i) res_vld_q <= 1'b0;
    end
  end

  assign empty_o     = !res_vld_q;
  assign valid_res_o = res_ok_q;
  assign epoch_ns_o  = res_ns_q;

  // an invalid result always carries zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_ok_q) |-> (res_ns_q == 64'sd0))
    else $error("invalid result with nonzero time");

  // a waiting result is never overwritten before it is popped
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !pop_i) |=> (res_vld_q && $stable(res_ns_q) && $stable(res_ok_q)))
    else $error("waiting result changed");

  // a record leaves the queue only when the converter is free
  a_deq_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |-> ((st_q == ute_pkg::ST_IDLE) && !q_empty_i))
    else $error("dequeue while busy or from empty queue");

  // the sequence always returns to idle through the result step
  a_idle_from_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q != ute_pkg::ST_IDLE) && (st_d == ute_pkg::ST_IDLE)) |-> res_wr)
    else $error("converter dropped a record");

endmodule

/* design/utc_timestamp_to_epoch_ns_unit.sv */
// ----------------------------------------------------------------------------
// utc_timestamp_to_epoch_ns_unit: UTC timestamp string to epoch nanoseconds
// Parses YYYY-MM-DDTHH:MM:SS[.fffffffff]Z one character per beat and returns
// a valid flag and signed 64-bit nanoseconds since 1970-01-01T00:00:00Z.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive char_in_i and is_last_i, raise
//   push; a beat is taken at each clock edge with push high and full low.
//   The parser takes one character per cycle while full is low. On the
//   beat marked is_last_i the parsed string goes into a two-entry record
//   queue; full rises while it holds two strings and holds off more characters.
//   Output side is a queue read port: while empty is low, valid_res_o and
//   epoch_ns_o show the oldest result; pop high with empty low takes it.
//   Exactly one result follows each string, in order.
// Conversion:
//   The converter is a sequencer of 8 states (IDLE, DIV, DAYA, DAYB, SECS,
//   MLO, MHI, SUM) and takes one string at a time: it takes the next string
//   from the queue only in IDLE, after the last result has been written.
// Stall and reset:
//   If the receiver does not pop, the result waits in the output register,
//   the converter holds its next result, the queue fills and then full
//   rises. Reset clears the parser, the queue and the result slot; no result
//   is pending after reset.
// ----------------------------------------------------------------------------
module utc_timestamp_to_epoch_ns_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_in_i,
  input  logic               is_last_i,
  output logic               empty,
  input  logic               pop,
  output logic               valid_res_o,
  output logic signed [63:0] epoch_ns_o
);

  logic              accept;
  logic              enq;
  logic              deq;
  logic              q_empty;
  logic              q_full;
  ute_pkg::ute_rec_t rec_in;
  ute_pkg::ute_rec_t rec_out;
  logic              res_empty;

  // a beat is taken only while the record queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  ute_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .char_in_i (char_in_i),
    .is_last_i (is_last_i),
    .enq_o     (enq),
    .rec_o     (rec_in)
  );

  ute_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .rec_i   (rec_in),
    .deq_i   (deq),
    .rec_o   (rec_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // pop only counts while a result is shown
  ute_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_out),
    .q_empty_i   (q_empty),
    .deq_o       (deq),
    .pop_i       (pop && !res_empty),
    .empty_o     (res_empty),
    .valid_res_o (valid_res_o),
    .epoch_ns_o  (epoch_ns_o)
  );

  assign empty = res_empty;

endmodule
